FILE: hw/rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsv_pkg;

  localparam logic [8:0]  HueMax   = 9'd359;
  localparam logic [6:0]  PctMax   = 7'd100;
  localparam logic [5:0]  Sixty    = 6'd60;
  // channel = floor(x * 255 / 600000) = floor(floor(x * 17 / 64) / 625)
  localparam logic [4:0]  ChanMul  = 5'd17;
  localparam int          ChanShr  = 6;
  localparam logic [9:0]  DivBase  = 10'd625;
  localparam logic [17:0] DivRecip = 18'd214748;   // floor(2^27 / 625)
  localparam int          DivShr   = 27;
  localparam logic [7:0]  ChanMax  = 8'd255;

  // Six 60-degree sectors, named by the channel that holds chroma,
  // then the one that holds the secondary component.
  typedef enum logic [2:0] {
    SEC_R_G = 3'd0,
    SEC_G_R = 3'd1,
    SEC_G_B = 3'd2,
    SEC_B_G = 3'd3,
    SEC_B_R = 3'd4,
    SEC_R_B = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e    sector;
    logic [6:0] sat;
    logic [6:0] val;
    logic [5:0] weight;   // 60 - |(h mod 120) - 60|
  } hsv_norm_t;

  typedef struct packed {
    sector_e     sector;
    logic [13:0] sv;       // s * v
    logic [13:0] vs;       // v * (100 - s)
    logic [5:0]  weight;
  } hsv_prod_t;

  typedef struct packed {
    sector_e     sector;
    logic [19:0] chroma;
    logic [19:0] second;
    logic [19:0] offs;
  } hsv_term_t;

  // per channel: 0 red, 1 green, 2 blue
  typedef logic [2:0][17:0] hsv_scaled_t;

  typedef struct packed {
    logic [2:0][17:0] z;
    logic [2:0][8:0]  q0;
  } hsv_quot_t;

  typedef logic [2:0][7:0] rgb_t;

endpackage

FILE: hw/rtl/hsv_if.sv
// Valid/ready channel interfaces for HSV requests and RGB results.
interface hsv_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: hw/rtl/hsv_front.sv
// Input saturation, hue sector/weight, and the two S/V products.
module hsv_front import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [8:0] hue_i,
  input  logic [6:0] sat_i,
  input  logic [6:0] val_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output hsv_prod_t  out_data_o
);

  logic      s1_vld_q, s2_vld_q;
  logic      s1_en, s2_en;
  hsv_norm_t s1_d, s1_q;
  hsv_prod_t s2_d, s2_q;

  logic [8:0] h_sat;
  logic [8:0] h_mod;
  logic [8:0] hue_dist;

  assign s2_en = !s2_vld_q || out_ready_i;
  assign s1_en = !s1_vld_q || s2_en;

  always_comb begin
    h_sat      = (hue_i > HueMax) ? HueMax : hue_i;
    s1_d.sat   = (sat_i > PctMax) ? PctMax : sat_i;
    s1_d.val   = (val_i > PctMax) ? PctMax : val_i;
    priority if (h_sat >= 9'd240) begin
      h_mod = h_sat - 9'd240;
    end else if (h_sat >= 9'd120) begin
      h_mod = h_sat - 9'd120;
    end else begin
      h_mod = h_sat;
    end
    hue_dist = (h_mod >= {3'd0, Sixty}) ? (h_mod - {3'd0, Sixty})
                                        : ({3'd0, Sixty} - h_mod);
    s1_d.weight = Sixty - hue_dist[5:0];
    priority if (h_sat < 9'd60) begin
      s1_d.sector = SEC_R_G;
    end else if (h_sat < 9'd120) begin
      s1_d.sector = SEC_G_R;
    end else if (h_sat < 9'd180) begin
      s1_d.sector = SEC_G_B;
    end else if (h_sat < 9'd240) begin
      s1_d.sector = SEC_B_G;
    end else if (h_sat < 9'd300) begin
      s1_d.sector = SEC_B_R;
    end else begin
      s1_d.sector = SEC_R_B;
    end
  end

  always_comb begin
    s2_d.sector = s1_q.sector;
    s2_d.weight = s1_q.weight;
    s2_d.sv     = {7'd0, s1_q.sat} * {7'd0, s1_q.val};
    s2_d.vs     = {7'd0, s1_q.val} * {7'd0, PctMax - s1_q.sat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= in_valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) s1_q <= s1_d;
    if (s2_en && s1_vld_q)   s2_q <= s2_d;
  end

  assign in_ready_o  = s1_en;
  assign out_valid_o = s2_vld_q;
  assign out_data_o  = s2_q;

endmodule

FILE: hw/rtl/hsv_mix.sv
// Scaled chroma/secondary/offset terms, then per-channel sum times 17 / 64.
module hsv_mix import hsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hsv_prod_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hsv_scaled_t out_data_o
);

  logic        s3_vld_q, s4_vld_q;
  logic        s3_en, s4_en;
  hsv_term_t   s3_d, s3_q;
  hsv_scaled_t s4_d, s4_q;
  logic [2:0][19:0] comp;
  logic [2:0][19:0] sum;
  logic [2:0][23:0] prod;

  assign s4_en = !s4_vld_q || out_ready_i;
  assign s3_en = !s3_vld_q || s4_en;

  always_comb begin
    s3_d.sector = in_data_i.sector;
    s3_d.chroma = {6'd0, in_data_i.sv} * {14'd0, Sixty};
    s3_d.second = {6'd0, in_data_i.sv} * {14'd0, in_data_i.weight};
    s3_d.offs   = {6'd0, in_data_i.vs} * {14'd0, Sixty};
  end

  always_comb begin
    unique case (s3_q.sector)
      SEC_R_G: begin comp[0] = s3_q.chroma; comp[1] = s3_q.second; comp[2] = '0;          end
      SEC_G_R: begin comp[0] = s3_q.second; comp[1] = s3_q.chroma; comp[2] = '0;          end
      SEC_G_B: begin comp[0] = '0;          comp[1] = s3_q.chroma; comp[2] = s3_q.second; end
      SEC_B_G: begin comp[0] = '0;          comp[1] = s3_q.second; comp[2] = s3_q.chroma; end
      SEC_B_R: begin comp[0] = s3_q.second; comp[1] = '0;          comp[2] = s3_q.chroma; end
      SEC_R_B: begin comp[0] = s3_q.chroma; comp[1] = '0;          comp[2] = s3_q.second; end
      default: begin comp[0] = '0;          comp[1] = '0;          comp[2] = '0;          end
    endcase
    for (int c = 0; c < 3; c++) begin
      // sum <= 600000, fits 20 bits; times 17 fits 24 bits
      sum[c]  = comp[c] + s3_q.offs;
      prod[c] = {4'd0, sum[c]} * {19'd0, ChanMul};
      s4_d[c] = prod[c][ChanShr +: 18];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s3_en) s3_vld_q <= in_valid_i;
      if (s4_en) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && in_valid_i) s3_q <= s3_d;
    if (s4_en && s3_vld_q)   s4_q <= s4_d;
  end

  assign in_ready_o  = s3_en;
  assign out_valid_o = s4_vld_q;
  assign out_data_o  = s4_q;

endmodule

FILE: hw/rtl/hsv_quant.sv
// Divide by 625 via reciprocal multiply plus one correction step.
module hsv_quant import hsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hsv_scaled_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rgb_t        out_data_o
);

  logic      s5_vld_q, s6_vld_q;
  logic      s5_en, s6_en;
  hsv_quot_t s5_d, s5_q;
  rgb_t      s6_d, s6_q;
  logic [2:0][35:0] recip;
  logic [2:0][17:0] back;
  logic [2:0][17:0] rem;
  logic [2:0][8:0]  q;

  assign s6_en = !s6_vld_q || out_ready_i;
  assign s5_en = !s5_vld_q || s6_en;

  // estimate is exact or one low
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      recip[c]   = {18'd0, in_data_i[c]} * {18'd0, DivRecip};
      s5_d.z[c]  = in_data_i[c];
      s5_d.q0[c] = recip[c][DivShr +: 9];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      back[c] = {9'd0, s5_q.q0[c]} * {8'd0, DivBase};
      rem[c]  = s5_q.z[c] - back[c];
      q[c]    = (rem[c] >= {8'd0, DivBase}) ? (s5_q.q0[c] + 9'd1) : s5_q.q0[c];
      s6_d[c] = (q[c] > {1'b0, ChanMax}) ? ChanMax : q[c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      if (s5_en) s5_vld_q <= in_valid_i;
      if (s6_en) s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_en && in_valid_i) s5_q <= s5_d;
    if (s6_en && s5_vld_q)   s6_q <= s6_d;
  end

  assign in_ready_o  = s5_en;
  assign out_valid_o = s6_vld_q;
  assign out_data_o  = s6_q;

endmodule

FILE: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: six-stage pipeline, one request per cycle.
// A request is registered in stage 1 on its accepting edge and moves through
// the stage registers in order; rgb_o.valid rises when it reaches stage 6.
// Throughput: one request per clock unless a stall at rgb_o backs up; each stage
// holds a valid bit and loads whenever it is empty or its successor advances, so
// stalls drop nothing. Multiplier chain: S*V, x60 / x weight, x17, reciprocal.
// Reset (rst_ni low, async) clears all stage valid bits; no data is cleared.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsv_in_if.sink    hsv_i,
  rgb_out_if.source rgb_o
);

  // front: stage 1 clamps inputs and finds the hue sector and weight,
  // stage 2 forms s*v and v*(100-s)
  logic        fr_valid, fr_ready;
  hsv_prod_t   fr_data;

  // mix: stage 3 scales to the 600000 grid, stage 4 routes terms to
  // channels by sector and pre-scales by 17/64
  logic        mx_valid, mx_ready;
  hsv_scaled_t mx_data;

  // quant: stage 5 reciprocal estimate of /625, stage 6 corrects and holds
  // the output register
  rgb_t        rgb_data;

  hsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsv_i.valid),
    .in_ready_o  (hsv_i.ready),
    .hue_i       (hsv_i.hue),
    .sat_i       (hsv_i.saturation),
    .val_i       (hsv_i.brightness),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  hsv_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (mx_valid),
    .out_ready_i (mx_ready),
    .out_data_o  (mx_data)
  );

  hsv_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mx_valid),
    .in_ready_o  (mx_ready),
    .in_data_i   (mx_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (rgb_data)
  );

  assign rgb_o.red   = rgb_data[0];
  assign rgb_o.green = rgb_data[1];
  assign rgb_o.blue  = rgb_data[2];

endmodule
